@@ design/sds_pkg.sv @@
// sds_pkg: types, constants and helpers for the sph density summation block
// no dependencies
package sds_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DensityW = 40;
  localparam int unsigned QFrac    = 24;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned SqrtStepsPerCycle = 4;

  localparam logic [31:0] InvHReset = 32'd6553600;
  localparam logic [31:0] MassReset = 32'd65536;

  localparam logic [0:0] RegInvH = 1'b0;
  localparam logic [0:0] RegMass = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] own_x;
    logic signed [CoordW-1:0] own_y;
    logic signed [CoordW-1:0] neighbour_x;
    logic signed [CoordW-1:0] neighbour_y;
    logic                     last_neighbour;
  } in_item_t;

  typedef struct packed {
    logic [DensityW-1:0] density;
    logic                saturated;
  } out_item_t;

  // one queued job: absolute coordinate differences and the end flag
  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic        last;
  } job_t;

endpackage

@@ design/sds_front.sv @@
// sds_front: accepts input beats, forms absolute differences, queues jobs
// depends on sds_pkg
module sds_front #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sds_pkg::in_item_t in_data_i,
  output logic             job_valid_o,
  input  logic             job_pop_i,
  output sds_pkg::job_t    job_o
);
  import sds_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push;
  job_t            job_new;
  logic signed [32:0] dx, dy;

  assign dx = 33'(in_data_i.neighbour_x) - 33'(in_data_i.own_x);
  assign dy = 33'(in_data_i.neighbour_y) - 33'(in_data_i.own_y);

  always_comb begin
    job_new.ax   = dx[32] ? 33'(-dx) : 33'(dx);
    job_new.ay   = dy[32] ? 33'(-dy) : 33'(dy);
    job_new.last = in_data_i.last_neighbour;
  end

  assign in_stall_o  = (cnt_q == (PtrW+1)'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (job_pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(job_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> job_valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !job_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");

endmodule

@@ design/sds_back.sv @@
// sds_back: sequential kernel evaluation, accumulation and result register
// depends on sds_pkg
module sds_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       inv_h_i,
  input  logic [31:0]       mass_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  sds_pkg::job_t     job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sds_pkg::out_item_t out_data_o
);
  import sds_pkg::*;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StSqx   = 12'b000000000010,
    StSqy   = 12'b000000000100,
    StSqrt  = 12'b000000001000,
    StQhi   = 12'b000000010000,
    StQlo   = 12'b000000100000,
    StP2    = 12'b000001000000,
    StP3    = 12'b000010000000,
    StW     = 12'b000100000000,
    StTerm  = 12'b001000000000,
    StMul   = 12'b010000000000,
    StAcc   = 12'b100000000000
  } state_e;

  state_e       state_q, state_d;
  job_t         job_q;
  logic [65:0]  sq_q;
  logic [67:0]  rem_q;
  logic [32:0]  root_q;
  logic [5:0]   step_q;
  logic [49:0]  q_q;      // q in Q.24, below 2^49 (dist < 2^33, 1/h < 2^32)
  logic [25:0]  base_q;   // q or 2-q, below 2^25 on the used paths
  logic         inner_q;
  logic [47:0]  p2_q, p3_q;
  logic [24:0]  w_q;
  logic [39:0]  term_q;
  logic [39:0]  sum_q;
  logic         clip_q;
  out_item_t    out_q;
  logic         out_valid_q;

  // sqrt: several radix-4 steps a cycle
  logic [67:0]  rem_c [SqrtStepsPerCycle+1];
  logic [32:0]  root_c [SqrtStepsPerCycle+1];
  logic [67:0]  trial_c [SqrtStepsPerCycle];
  logic [1:0]   pair_c [SqrtStepsPerCycle];

  always_comb begin
    rem_c[0]  = rem_q;
    root_c[0] = root_q;
    for (int k = 0; k < SqrtStepsPerCycle; k++) begin
      pair_c[k]  = sq_q[65 - 2*k -: 2];
      trial_c[k] = {33'd0, root_c[k], 2'b01};
      rem_c[k+1] = {rem_c[k][65:0], pair_c[k]};
      if (rem_c[k+1] >= trial_c[k]) begin
        rem_c[k+1]  = rem_c[k+1] - trial_c[k];
        root_c[k+1] = {root_c[k][31:0], 1'b1};
      end else begin
        root_c[k+1] = {root_c[k][31:0], 1'b0};
      end
    end
  end

  logic [40:0] sum_ext;
  logic        result_go;
  assign sum_ext   = {1'b0, sum_q} + {1'b0, term_q};
  assign result_go = (state_q == StAcc) && job_q.last;
  assign job_pop_o = (state_q == StIdle) && job_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (job_valid_i) state_d = StSqx;
      StSqx:  state_d = StSqy;
      StSqy:  state_d = StSqrt;
      StSqrt: if (step_q == 6'd32) state_d = StQhi;
      StQhi:  state_d = StQlo;
      StQlo:  state_d = StP2;
      StP2:   state_d = StP3;
      StP3:   state_d = StW;
      StW:    state_d = StTerm;
      StTerm: state_d = StMul;
      StMul:  state_d = StAcc;
      StAcc:  if (!(job_q.last && out_valid_q && out_stall_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        job_q  <= job_i;
        rem_q  <= '0;
        root_q <= '0;
      end
      StSqx: sq_q <= 66'(job_q.ax) * 66'(job_q.ax);
      StSqy: sq_q <= sq_q + 66'(job_q.ay) * 66'(job_q.ay);
      StSqrt: begin
        // the final step is pair 0 alone (33 pairs total)
        if (step_q == 6'd32) begin
          rem_q  <= rem_c[1];
          root_q <= root_c[1];
        end else begin
          rem_q  <= rem_c[SqrtStepsPerCycle];
          root_q <= root_c[SqrtStepsPerCycle];
          sq_q   <= {sq_q[65-2*SqrtStepsPerCycle:0], {(2*SqrtStepsPerCycle){1'b0}}};
        end
      end
      StQhi: q_q <= 50'(root_q[32:16]) * 50'(inv_h_i);
      StQlo: begin
        q_q <= q_q + ((50'(root_q[15:0]) * 50'(inv_h_i)) >> 16);
      end
      StP2: begin
        inner_q <= (q_q <= 50'(1 << QFrac));
        base_q  <= (q_q <= 50'(1 << QFrac)) ? q_q[25:0] : 26'((2 << QFrac) - q_q[25:0]);
        p2_q    <= '0;
      end
      StP3: p2_q <= 48'((52'(base_q) * 52'(base_q)) >> QFrac);
      StW:  p3_q <= 48'((52'(p2_q[25:0]) * 52'(base_q)) >> QFrac);
      StTerm: begin
        if (inner_q) begin
          w_q <= 25'((26'(1 << QFrac) + 26'((3 * p3_q[25:0]) >> 2)) -
                     26'((3 * p2_q[25:0]) >> 1));
        end else begin
          w_q <= 25'(p3_q[25:0] >> 2);
        end
      end
      default: ;
    endcase
  end

  logic [56:0] prod_c;
  logic [39:0] term_c;
  assign prod_c = mass_i * w_q;
  assign term_c = far_q ? '0 : 40'(prod_c >> QFrac);

  // far flag evaluated when q is complete, term registered before accumulate
  logic far_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StP2) far_q <= (q_q >= 50'(2 << QFrac));
    if (state_q == StMul) term_q <= term_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StSqy) step_q <= '0;
      else if (state_q == StSqrt) step_q <= step_q + 6'(SqrtStepsPerCycle);
      if (state_q == StAcc && state_d == StIdle) begin
        if (job_q.last) begin
          out_q.density   <= sum_ext[40] ? '1 : sum_ext[39:0];
          out_q.saturated <= clip_q | sum_ext[40];
          sum_q  <= '0;
          clip_q <= 1'b0;
        end else begin
          sum_q  <= sum_ext[40] ? '1 : sum_ext[39:0];
          clip_q <= clip_q | sum_ext[40];
        end
      end
      if (result_go && state_d == StIdle) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> state_q == StSqx) else $error("job not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("result dropped");

endmodule

@@ design/sph_density_summation.sv @@
// sph_density_summation: top level, apb registers, front queue and back unit
// depends on sds_pkg, sds_front, sds_back
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall  | in_item_t
//  out     | output    | out_valid/out_stall| out_item_t
//  apb     | input     | psel/penable       | 32-bit register
//
// the back unit takes one neighbour at a time: it takes the job, squares x and
// then y, runs the radix-4 square root at four digits a cycle (one in its final
// step), then forms q, the polynomial, the mass product and the accumulate. the
// front queue keeps taking beats while the back unit works, until it is full.
// reset clears the sum, the queue and the registers to their defaults. a stalled
// result holds and blocks the next last beat.
module sph_density_summation #(
  parameter int unsigned QueueDepth = sds_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sds_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sds_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sds_pkg::*;

  logic [31:0] inv_h_q, mass_q;
  logic        job_valid, job_pop;
  job_t        job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMass) ? mass_q : inv_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_h_q <= InvHReset;
      mass_q  <= MassReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        RegInvH: inv_h_q <= pwdata;
        RegMass: mass_q  <= pwdata;
        default: ;
      endcase
    end
  end

  sds_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  sds_back u_back (
    .clk_i, .rst_ni, .inv_h_i(inv_h_q), .mass_i(mass_q),
    .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
